FILE: hw/rtl/weighted_gradient_histogram_assert.svh
// Assertion macros shared by the histogram RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef WEIGHTED_GRADIENT_HISTOGRAM_ASSERT_SVH
`define WEIGHTED_GRADIENT_HISTOGRAM_ASSERT_SVH
`ifndef SYNTH
`define WGH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WGH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WGH_ASSERT(lbl, prop, msg)
`define WGH_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/wgh_pkg.sv
// Package for the weighted gradient histogram: sizes, codes, types, sum helpers.
// No dependencies; used by the channel interfaces and all RTL modules.
`default_nettype none

package wgh_pkg;

  // Storage and field sizes
  localparam int unsigned BIN_DEPTH = 256;
  localparam int unsigned SUM_WIDTH = 48;
  localparam int unsigned ADDR_W    = $clog2(BIN_DEPTH);
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned SMP_W     = 24;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned OUT_SUM_W = 48;
  localparam int unsigned WSUM_W    = 40;
  localparam int unsigned PROD_W    = SMP_W + WGT_W + 1;
  localparam int unsigned ADD_W     = ((SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W) + 1;
  localparam int unsigned EXT_W     = (SUM_WIDTH > OUT_SUM_W) ? SUM_WIDTH : OUT_SUM_W;
  localparam int unsigned LIM_W     = IDX_W + 1;

  localparam logic [CNT_W-1:0] BINS_RESET = CNT_W'(256);
  localparam logic [LIM_W-1:0] BINS_MAX   = LIM_W'(BIN_DEPTH);

  // Item codes
  typedef enum logic {
    KIND_ACC  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic fetch;
    logic commit;
  } wgh_cmd_t;

  // One bin of the store
  typedef struct packed {
    logic                        sat;
    logic [WSUM_W-1:0]           wsum;
    logic signed [SUM_WIDTH-1:0] hsum;
    logic signed [SUM_WIDTH-1:0] gsum;
  } bin_entry_t;

  // Saturating add; MSB of the result flags a clamp
  function automatic logic [SUM_WIDTH:0] sat_add(input logic signed [SUM_WIDTH-1:0] s,
                                                 input logic signed [PROD_W-1:0] p);
    logic signed [ADD_W-1:0] t;
    logic signed [ADD_W-1:0] hi;
    logic signed [ADD_W-1:0] lo;
    t  = ADD_W'(s) + ADD_W'(p);
    hi = {{(ADD_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (t > hi) begin
      return {1'b1, hi[SUM_WIDTH-1:0]};
    end else if (t < lo) begin
      return {1'b1, lo[SUM_WIDTH-1:0]};
    end
    return {1'b0, t[SUM_WIDTH-1:0]};
  endfunction

  // Clamp a stored sum to the reported width
  function automatic logic [OUT_SUM_W-1:0] clamp_out(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [EXT_W-1:0] x;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    x  = EXT_W'(v);
    hi = {{(EXT_W-OUT_SUM_W+1){1'b0}}, {(OUT_SUM_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      x = hi;
    end else if (x < lo) begin
      x = lo;
    end
    return x[OUT_SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wgh_if.sv
// Valid/ready channel interfaces: sample items, result items, bin count writes.
// Depends on wgh_pkg for field widths.
`default_nettype none

interface wgh_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [wgh_pkg::IDX_W-1:0]         bin_index;
  logic signed [wgh_pkg::SMP_W-1:0]  gradient;
  logic signed [wgh_pkg::SMP_W-1:0]  hessian;
  logic [wgh_pkg::WGT_W-1:0]         weight;

  modport source (output valid, kind, bin_index, gradient, hessian, weight, input ready);
  modport sink   (input valid, kind, bin_index, gradient, hessian, weight, output ready);
endinterface

interface wgh_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  status;
  logic signed [wgh_pkg::OUT_SUM_W-1:0]  gradient_sum;
  logic signed [wgh_pkg::OUT_SUM_W-1:0]  hessian_sum;
  logic [wgh_pkg::WSUM_W-1:0]            weight_sum;
  logic                                  saturated;

  modport source (output valid, status, gradient_sum, hessian_sum, weight_sum, saturated,
                  input ready);
  modport sink   (input valid, status, gradient_sum, hessian_sum, weight_sum, saturated,
                  output ready);
endinterface

interface wgh_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wgh_pkg::CNT_W-1:0] bins_in_use;

  modport source (output valid, bins_in_use, input ready);
  modport sink   (input valid, bins_in_use, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wgh_ctrl.sv
// Controller for the histogram: sequences capture, store fetch and commit per item.
// Depends on wgh_pkg and the assertion macro header.
`default_nettype none
`include "weighted_gradient_histogram_assert.svh"

module wgh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output wgh_pkg::wgh_cmd_t      cmd_o
);
  import wgh_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result slot can take a new item this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `WGH_ASSERT(a_cmd_excl, $onehot0(cmd_o), "more than one datapath command at once")
  `WGH_ASSERT(a_capture_fetch, cmd_o.capture |=> cmd_o.fetch, "capture not followed by fetch")
  `WGH_ASSERT(a_commit_valid, cmd_o.commit |=> out_valid_q, "commit did not raise result valid")
  `WGH_ASSERT(a_no_clobber, (out_valid_q && !out_ready_i) |-> !cmd_o.commit,
              "commit over a result not yet taken")
  `WGH_ASSERT_RST(a_rst_idle, !rst_ni |=> !out_valid_q, "result valid set out of reset")

endmodule

`default_nettype wire

FILE: hw/rtl/wgh_dpath.sv
// Datapath for the histogram: item registers, bin store, multipliers, saturating sums.
// Depends on wgh_pkg and the assertion macro header.
`default_nettype none
`include "weighted_gradient_histogram_assert.svh"

module wgh_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire wgh_pkg::wgh_cmd_t                 cmd_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [wgh_pkg::CNT_W-1:0]         cfg_bins_i,
  input  wire logic                              kind_i,
  input  wire logic [wgh_pkg::IDX_W-1:0]         bin_index_i,
  input  wire logic signed [wgh_pkg::SMP_W-1:0]  gradient_i,
  input  wire logic signed [wgh_pkg::SMP_W-1:0]  hessian_i,
  input  wire logic [wgh_pkg::WGT_W-1:0]         weight_i,
  output logic                                   status_o,
  output logic signed [wgh_pkg::OUT_SUM_W-1:0]   gradient_sum_o,
  output logic signed [wgh_pkg::OUT_SUM_W-1:0]   hessian_sum_o,
  output logic [wgh_pkg::WSUM_W-1:0]             weight_sum_o,
  output logic                                   saturated_o
);
  import wgh_pkg::*;

  // Configuration and per-bin valid bits
  logic [CNT_W-1:0]     bins_q;
  logic [BIN_DEPTH-1:0] valid_q;

  // Captured item
  kind_e                   kind_q;
  logic [ADDR_W-1:0]       addr_q;
  logic                    in_range_q;
  logic signed [SMP_W-1:0] grad_q;
  logic signed [SMP_W-1:0] hess_q;
  logic [WGT_W-1:0]        wgt_q;

  // Fetch stage
  bin_entry_t               mem_q [BIN_DEPTH];
  bin_entry_t               rd_entry_q;
  logic                     rd_valid_q;
  logic signed [PROD_W-1:0] prod_g_q;
  logic signed [PROD_W-1:0] prod_h_q;

  // Result registers
  logic                        status_q;
  logic signed [OUT_SUM_W-1:0] gsum_q;
  logic signed [OUT_SUM_W-1:0] hsum_q;
  logic [WSUM_W-1:0]           wsum_q;
  logic                        sat_q;

  logic [LIM_W-1:0]   bins_ext;
  logic [LIM_W-1:0]   limit;
  logic               in_range;
  bin_entry_t         cur;
  bin_entry_t         upd;
  bin_entry_t         res;
  logic [SUM_WIDTH:0] gadd;
  logic [SUM_WIDTH:0] hadd;
  logic [WSUM_W:0]    wadd;
  logic               wsat;
  logic               acc_we;

  // Range check against min(bins_in_use, BIN_DEPTH)
  assign bins_ext = LIM_W'(bins_q);
  assign limit    = (bins_ext > BINS_MAX) ? BINS_MAX : bins_ext;
  assign in_range = LIM_W'(bin_index_i) < limit;

  // Bin count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_RESET;
    end else if (cfg_we_i) begin
      bins_q <= cfg_bins_i;
    end
  end

  // Item capture and products
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= kind_e'(kind_i);
      addr_q     <= bin_index_i[ADDR_W-1:0];
      in_range_q <= in_range;
      grad_q     <= gradient_i;
      hess_q     <= hessian_i;
      wgt_q      <= weight_i;
    end
    if (cmd_i.fetch) begin
      prod_g_q <= grad_q * $signed({1'b0, wgt_q});
      prod_h_q <= hess_q * $signed({1'b0, wgt_q});
    end
  end

  // Never-written or cleared bins read as zero
  assign cur = rd_valid_q ? rd_entry_q : '0;

  // Saturating update
  always_comb begin
    gadd      = sat_add(cur.gsum, prod_g_q);
    hadd      = sat_add(cur.hsum, prod_h_q);
    wadd      = {1'b0, cur.wsum} + (WSUM_W+1)'(wgt_q);
    wsat      = wadd[WSUM_W];
    upd.gsum  = gadd[SUM_WIDTH-1:0];
    upd.hsum  = hadd[SUM_WIDTH-1:0];
    upd.wsum  = wsat ? '1 : wadd[WSUM_W-1:0];
    upd.sat   = cur.sat || gadd[SUM_WIDTH] || hadd[SUM_WIDTH] || wsat;
    res       = (kind_q == KIND_ACC) ? upd : cur;
  end

  assign acc_we = cmd_i.commit && in_range_q && (kind_q == KIND_ACC);

  // Bin store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      mem_q[addr_q] <= upd;
    end
    if (cmd_i.fetch) begin
      rd_entry_q <= mem_q[addr_q];
    end
  end

  // Valid bits: set by accumulate, cleared by read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fetch) begin
        rd_valid_q <= valid_q[addr_q];
      end
      if (cmd_i.commit && in_range_q) begin
        valid_q[addr_q] <= (kind_q == KIND_ACC);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (in_range_q) begin
        status_q <= STATUS_OK;
        gsum_q   <= clamp_out(res.gsum);
        hsum_q   <= clamp_out(res.hsum);
        wsum_q   <= res.wsum;
        sat_q    <= res.sat;
      end else begin
        status_q <= STATUS_RANGE;
        gsum_q   <= '0;
        hsum_q   <= '0;
        wsum_q   <= '0;
        sat_q    <= 1'b0;
      end
    end
  end

  assign status_o       = status_q;
  assign gradient_sum_o = gsum_q;
  assign hessian_sum_o  = hsum_q;
  assign weight_sum_o   = wsum_q;
  assign saturated_o    = sat_q;

  `WGH_ASSERT(a_range_zero, (cmd_i.commit && !in_range_q) |=> (status_q && wsum_q == '0 && !sat_q),
              "out-of-range item did not give a zero error result")
  `WGH_ASSERT(a_wsat_mark, (acc_we && wsat) |=> (sat_q && wsum_q == '1),
              "weight clamp did not mark the bin")
  `WGH_ASSERT(a_read_clears, (cmd_i.commit && in_range_q && kind_q == KIND_READ) |=>
              !valid_q[$past(addr_q)], "read did not clear the bin")

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_gradient_histogram.sv
// Top level of the weighted gradient/hessian histogram.
// Depends on wgh_pkg, wgh_if.sv, wgh_ctrl and wgh_dpath.
//
//  channel | dir | payload                                              | accepted when
//  smp_i   | in  | kind, bin_index, gradient, hessian, weight           | valid && ready
//  res_o   | out | status, gradient_sum, hessian_sum, weight_sum, sat.  | valid && ready
//  cfg_i   | in  | bins_in_use                                          | valid && ready
//
// Each item goes from accept to result through capture, store read plus
// multiply, then saturating add with write-back. A new item is taken only after the
// last one has committed; the read-modify-write of the bin store sets that.
// Reset zeroes the per-bin valid bits at once, so no clearing pass is needed.
// A result not yet taken stalls the next item in its commit cycle only.
// cfg_i is always ready.
`default_nettype none

module weighted_gradient_histogram (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wgh_in_if.sink    smp_i,
  wgh_out_if.source res_o,
  wgh_cfg_if.sink   cfg_i
);
  import wgh_pkg::*;

  wgh_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  wgh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  wgh_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_i.valid),
    .cfg_bins_i     (cfg_i.bins_in_use),
    .kind_i         (smp_i.kind),
    .bin_index_i    (smp_i.bin_index),
    .gradient_i     (smp_i.gradient),
    .hessian_i      (smp_i.hessian),
    .weight_i       (smp_i.weight),
    .status_o       (res_o.status),
    .gradient_sum_o (res_o.gradient_sum),
    .hessian_sum_o  (res_o.hessian_sum),
    .weight_sum_o   (res_o.weight_sum),
    .saturated_o    (res_o.saturated)
  );

endmodule

`default_nettype wire
